FILE: rtl/core/ppt_pkg.sv
// ppt_pkg: shared types, constants and the arctangent table of the pose tracking controller
// used by every module under rtl/core; depends on nothing
`default_nettype none

package ppt_pkg;

  // field widths
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 24;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 18;
  localparam int RDIST_W = 24;
  localparam int RANG_W  = 18;
  localparam int OUT_W   = 19;

  // defaults handed to the top level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_SPEED_GAIN  = 3'd0,
    REG_ALPHA_GAIN  = 3'd1,
    REG_BETA_GAIN   = 3'd2,
    REG_SPEED_LIMIT = 3'd3,
    REG_TURN_LIMIT  = 3'd4,
    REG_REACH_DIST  = 3'd5,
    REG_REACH_ANGLE = 3'd6
  } reg_idx_t;

  localparam logic OP_TARGET = 1'b0;
  localparam logic OP_POSE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_TARGET = 2'b01,
    KIND_POSE   = 2'b10
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [HEAD_W-1:0]  h;
  } entry_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] speed_gain;
    logic signed [GAIN_W-1:0] alpha_gain;
    logic signed [GAIN_W-1:0] beta_gain;
    logic [LIM_W-1:0]         speed_limit;
    logic [LIM_W-1:0]         turn_limit;
    logic [RDIST_W-1:0]       reach_distance;
    logic [RANG_W-1:0]        reach_angle;
  } cfg_t;

  localparam logic signed [GAIN_W-1:0] SPEED_GAIN_RST  = 24'sd328;
  localparam logic signed [GAIN_W-1:0] ALPHA_GAIN_RST  = 24'sd360448;
  localparam logic signed [GAIN_W-1:0] BETA_GAIN_RST   = -24'sd249037;
  localparam logic [LIM_W-1:0]         SPEED_LIMIT_RST = 18'd65536;
  localparam logic [LIM_W-1:0]         TURN_LIMIT_RST  = 18'd65536;
  localparam logic [RDIST_W-1:0]       REACH_DIST_RST  = 24'd2621;
  localparam logic [RANG_W-1:0]        REACH_ANGLE_RST = 18'd11438;

  // arctangent of 2^-i in Q30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h3243F6A8;
      5'd1:    r = 32'h1DAC6705;
      5'd2:    r = 32'h0FADBAFC;
      5'd3:    r = 32'h07F56EA6;
      5'd4:    r = 32'h03FEAB76;
      5'd5:    r = 32'h01FFD55B;
      5'd6:    r = 32'h00FFFAAA;
      5'd7:    r = 32'h007FFF55;
      5'd8:    r = 32'h003FFFEA;
      5'd9:    r = 32'h001FFFFD;
      5'd10:   r = 32'h000FFFFF;
      5'd11:   r = 32'h0007FFFF;
      5'd12:   r = 32'h0003FFFF;
      5'd13:   r = 32'h0001FFFF;
      5'd14:   r = 32'h0000FFFF;
      5'd15:   r = 32'h00007FFF;
      5'd16:   r = 32'h00003FFF;
      5'd17:   r = 32'h00001FFF;
      5'd18:   r = 32'h00000FFF;
      5'd19:   r = 32'h000007FF;
      5'd20:   r = 32'h000003FF;
      5'd21:   r = 32'h000001FF;
      5'd22:   r = 32'h000000FF;
      5'd23:   r = 32'h0000007F;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ppt_front.sv
// ppt_front: input stage, takes beats and classifies them into queue entries
// depends on ppt_pkg
`default_nettype none

module ppt_front import ppt_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     operation,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [HEAD_W-1:0] heading,
  output logic                          push,
  output entry_t                        push_entry,
  input  wire logic                     full
);

  logic   hold_valid;
  entry_t hold;

  assign push       = hold_valid;
  assign push_entry = hold;
  assign in_ready   = !hold_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold.kind <= (operation == OP_POSE) ? KIND_POSE : KIND_TARGET;
      hold.x    <= pos_x;
      hold.y    <= pos_y;
      hold.h    <= heading;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppt_queue.sv
// ppt_queue: short fifo of classified entries between the front and back parts
// depends on ppt_pkg
`default_nettype none

module ppt_queue import ppt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppt_back.sv
// ppt_back: sequencer that holds the goal and runs the angle wrap, cordic and gain steps
// depends on ppt_pkg
`default_nettype none

module ppt_back import ppt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    q_valid,
  input  wire entry_t                  q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      speed,
  output logic signed [OUT_W-1:0]      turn_rate,
  output logic                         reached
);

  localparam int DATA_W = 46;
  localparam int ANG_W  = 35;
  localparam int WRAP_W = 41;
  localparam int DIFF_W = POS_W + 1;
  localparam int DIST_W = 36;
  localparam int KK_W   = 20;
  localparam int MAGP_W = DATA_W + KK_W;
  localparam int PV_W   = GAIN_W + DIST_W;
  localparam int PT_W   = GAIN_W + OUT_W;
  localparam int TS_W   = PT_W + 1;
  localparam int CX_W   = 31;
  localparam int SP_W   = OUT_W + CX_W + 1;
  localparam int CI_W   = $clog2(CORDIC_STEPS);

  localparam logic signed [ANG_W-1:0]  PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [WRAP_W-1:0] PI_W        = 41'sd3373259426;
  localparam logic signed [WRAP_W-1:0] TWO_PI_W    = 41'sd6746518852;
  localparam logic signed [WRAP_W-1:0] TWO_PI_64   = TWO_PI_W <<< 6;
  localparam logic signed [DATA_W-1:0] K_Q30       = 46'sd652032874;
  localparam logic signed [DATA_W-1:0] ONE_Q30     = 46'sd1073741824;
  localparam logic signed [KK_W-1:0]   KK_Q20      = 20'sd386669;
  localparam logic signed [MAGP_W-1:0] DIST_RND    = MAGP_W'(1) <<< 27;
  localparam logic signed [ANG_W-1:0]  Q16_RND     = 35'sd8192;
  localparam logic [3:0]               WRAP_LAST   = 4'd8;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_WRAP  = 11'b00000000010,
    S_ROT   = 11'b00000000100,
    S_VEC   = 11'b00000001000,
    S_DIST  = 11'b00000010000,
    S_ANG   = 11'b00000100000,
    S_REACH = 11'b00001000000,
    S_COS   = 11'b00010000000,
    S_MIX   = 11'b00100000000,
    S_DRIVE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [ANG_W-1:0]  z;
  } cvec_t;

  state_t state;

  // goal and tracking flag
  logic signed [POS_W-1:0]  gx;
  logic signed [POS_W-1:0]  gy;
  logic signed [HEAD_W-1:0] gh;
  logic                     tracking;

  // per-item working registers
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [HEAD_W-1:0] ph;
  logic signed [WRAP_W-1:0] w;
  logic [3:0]               wk;
  logic                     wsel;
  logic signed [ANG_W-1:0]  th;
  logic signed [ANG_W-1:0]  dth;
  logic signed [ANG_W-1:0]  alpha;
  logic signed [DATA_W-1:0] ca;
  logic signed [DATA_W-1:0] cb;
  logic signed [ANG_W-1:0]  cz;
  logic [CI_W-1:0]          ci;
  logic signed [DIST_W-1:0] goal_dist;
  logic signed [OUT_W-1:0]  a16;
  logic signed [OUT_W-1:0]  b16;
  logic signed [OUT_W-1:0]  dth16;
  logic signed [PV_W-1:0]   pv;
  logic signed [PT_W-1:0]   pa;
  logic signed [PT_W-1:0]   pb;
  logic signed [OUT_W-1:0]  v;
  logic [CX_W-1:0]          cx;
  logic signed [TS_W-1:0]   tsum;
  logic signed [OUT_W-1:0]  res_speed;
  logic signed [OUT_W-1:0]  res_turn;
  logic                     res_reached;

  // combinational helpers
  logic signed [WRAP_W-1:0] wrap_c;
  logic signed [WRAP_W-1:0] w_next;
  logic signed [DATA_W-1:0] sa;
  logic signed [DATA_W-1:0] sb;
  logic signed [ANG_W-1:0]  at;
  logic                     dir;
  logic signed [DATA_W-1:0] na;
  logic signed [DATA_W-1:0] nb;
  logic signed [ANG_W-1:0]  nz;
  logic                     last;
  logic signed [ANG_W-1:0]  alpha_w;
  logic signed [ANG_W-1:0]  bdiff;
  logic signed [ANG_W-1:0]  beta_w;
  logic signed [MAGP_W-1:0] magp;
  logic signed [OUT_W-1:0]  abs_dth;
  logic                     is_reach;
  logic signed [PV_W-1:0]   pvs;
  logic signed [PV_W-1:0]   vlim;
  logic signed [TS_W-1:0]   tss;
  logic signed [TS_W-1:0]   tlim;
  logic signed [SP_W-1:0]   sp;
  logic                     out_free;

  function automatic cvec_t rot_pre(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b,
                                    input logic signed [ANG_W-1:0]  z);
    cvec_t r;
    r.a = a;
    r.b = b;
    r.z = z;
    if (z > HALF_PI_Q30) begin
      r.a = -a;
      r.b = -b;
      r.z = z - PI_Q30;
    end else if (z < -HALF_PI_Q30) begin
      r.a = -a;
      r.b = -b;
      r.z = z + PI_Q30;
    end
    return r;
  endfunction

  function automatic cvec_t vec_pre(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    cvec_t r;
    r.a = a;
    r.b = b;
    r.z = '0;
    if (a < 0) begin
      r.a = -a;
      r.b = -b;
      r.z = (b >= 0) ? PI_Q30 : -PI_Q30;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q16(input logic signed [ANG_W-1:0] x);
    logic signed [ANG_W-1:0] t;
    t = (x + Q16_RND) >>> 14;
    return OUT_W'(t);
  endfunction

  // modulo 2*pi reduction, one compare and subtract a cycle
  always_comb begin
    wrap_c = TWO_PI_W <<< (3'(4'd7 - wk));
    if (wk == '0) begin
      w_next = (w < 0) ? w + TWO_PI_64 : w;
    end else if (wk == WRAP_LAST) begin
      w_next = (w > PI_W) ? w - TWO_PI_W : w;
    end else begin
      w_next = (w >= wrap_c) ? w - wrap_c : w;
    end
  end

  // one shared cordic iteration
  always_comb begin
    sa   = ca >>> ci;
    sb   = cb >>> ci;
    at   = $signed(ANG_W'(atan_q30(5'(ci))));
    dir  = (state == S_VEC) ? cb[DATA_W-1] : !cz[ANG_W-1];
    if (dir) begin
      na = ca - sb;
      nb = cb + sa;
      nz = cz - at;
    end else begin
      na = ca + sb;
      nb = cb - sa;
      nz = cz + at;
    end
    last = (ci == CI_W'(CORDIC_STEPS - 1));
  end

  always_comb begin
    if (nz > PI_Q30) begin
      alpha_w = nz - TWO_PI_Q30;
    end else if (nz <= -PI_Q30) begin
      alpha_w = nz + TWO_PI_Q30;
    end else begin
      alpha_w = nz;
    end
    bdiff = dth - alpha;
    if (bdiff > PI_Q30) begin
      beta_w = bdiff - TWO_PI_Q30;
    end else if (bdiff <= -PI_Q30) begin
      beta_w = bdiff + TWO_PI_Q30;
    end else begin
      beta_w = bdiff;
    end
    magp     = ca * KK_Q20 + DIST_RND;
    abs_dth  = dth16[OUT_W-1] ? -dth16 : dth16;
    is_reach = (goal_dist < $signed(DIST_W'(cfg.reach_distance)))
            && (abs_dth < $signed(OUT_W'(cfg.reach_angle)));
    pvs      = pv >>> 16;
    vlim     = PV_W'(cfg.speed_limit);
    tss      = tsum >>> 16;
    tlim     = TS_W'(cfg.turn_limit);
    sp       = v * $signed({1'b0, cx});
    out_free = !out_valid || out_ready;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tracking  <= 1'b0;
      gx        <= '0;
      gy        <= '0;
      gh        <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: loaded when the sequencer finishes, cleared when taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.kind == KIND_TARGET) begin
              gx       <= q_head.x;
              gy       <= q_head.y;
              gh       <= q_head.h;
              tracking <= 1'b1;
            end else if (tracking) begin
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          if (wk == WRAP_LAST) begin
            if (!wsel) begin
              state <= S_WRAP;
            end else if (dx == '0 && dy == '0) begin
              state <= S_ANG;
            end else begin
              state <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (last) begin
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (last) begin
            state <= S_DIST;
          end
        end
        S_DIST:  state <= S_ANG;
        S_ANG:   state <= S_REACH;
        S_REACH: begin
          if (is_reach) begin
            tracking <= 1'b0;
            state    <= S_DONE;
          end else begin
            state <= S_COS;
          end
        end
        S_COS: begin
          if (last) begin
            state <= S_MIX;
          end
        end
        S_MIX:   state <= S_DRIVE;
        S_DRIVE: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dx        <= DIFF_W'(gx) - DIFF_W'(q_head.x);
        dy        <= DIFF_W'(gy) - DIFF_W'(q_head.y);
        ph        <= q_head.h;
        w         <= WRAP_W'(q_head.h) <<< 14;
        wk        <= '0;
        wsel      <= 1'b0;
        goal_dist <= '0;
        alpha     <= '0;
      end
      S_WRAP: begin
        if (wk != WRAP_LAST) begin
          w  <= w_next;
          wk <= wk + 1'b1;
        end else if (!wsel) begin
          th   <= ANG_W'(w_next);
          w    <= WRAP_W'(DIFF_W'(gh) - DIFF_W'(ph)) <<< 14;
          wk   <= '0;
          wsel <= 1'b1;
        end else begin
          dth <= ANG_W'(w_next);
          {ca, cb, cz} <= rot_pre(DATA_W'(dx) <<< 8, DATA_W'(dy) <<< 8, -th);
          ci  <= '0;
        end
      end
      S_ROT: begin
        if (last) begin
          {ca, cb, cz} <= vec_pre(na, nb);
          ci <= '0;
        end else begin
          {ca, cb, cz} <= {na, nb, nz};
          ci <= ci + 1'b1;
        end
      end
      S_VEC: begin
        ci <= ci + 1'b1;
        {ca, cb, cz} <= {na, nb, nz};
        if (last) begin
          alpha <= alpha_w;
        end
      end
      S_DIST: begin
        goal_dist <= DIST_W'(magp >>> 28);
      end
      S_ANG: begin
        a16   <= to_q16(alpha);
        b16   <= to_q16(beta_w);
        dth16 <= to_q16(dth);
      end
      S_REACH: begin
        res_speed   <= '0;
        res_turn    <= '0;
        res_reached <= is_reach;
        pv <= cfg.speed_gain * goal_dist;
        pa <= cfg.alpha_gain * a16;
        pb <= cfg.beta_gain * b16;
        {ca, cb, cz} <= rot_pre(K_Q30, '0, alpha);
        ci <= '0;
      end
      S_COS: begin
        ci <= ci + 1'b1;
        {ca, cb, cz} <= {na, nb, nz};
        if (last) begin
          if (na < 0) begin
            cx <= '0;
          end else if (na > ONE_Q30) begin
            cx <= CX_W'(ONE_Q30);
          end else begin
            cx <= CX_W'(na);
          end
        end
      end
      S_MIX: begin
        if (pvs > vlim) begin
          v <= OUT_W'(vlim);
        end else if (pvs < -vlim) begin
          v <= OUT_W'(-vlim);
        end else begin
          v <= OUT_W'(pvs);
        end
        tsum <= TS_W'(pa) + TS_W'(pb);
      end
      S_DRIVE: begin
        res_speed <= OUT_W'(sp >>> 30);
        if (tss > tlim) begin
          res_turn <= OUT_W'(tlim);
        end else if (tss < -tlim) begin
          res_turn <= OUT_W'(-tlim);
        end else begin
          res_turn <= OUT_W'(tss);
        end
      end
      S_DONE: begin
        if (out_free) begin
          speed     <= res_speed;
          turn_rate <= res_turn;
          reached   <= res_reached;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/polar_pose_tracking_controller.sv
// polar_pose_tracking_controller: top level, configuration registers and apb port
// depends on ppt_pkg, ppt_front, ppt_queue, ppt_back
`default_nettype none

// Usage
//   input channel (in_valid / in_ready): one beat carries operation, pos_x, pos_y,
//   heading. operation 0 stores the goal pose and starts tracking, no result.
//   operation 1 is a pose update: ignored while not tracking, otherwise it gives
//   exactly one result beat on the output channel (out_valid / out_ready) with
//   speed, turn_rate and reached. on reached the drive is zero and tracking stops.
//   gains, limits and reach thresholds sit behind the apb port at 4*index.
// Sequence
//   a pose update runs through one shared cordic unit three times (rotate,
//   vector, cosine), with two angle wraps and issue, distance, gain and output
//   work in the back part, after the front register and the queue. the back
//   part takes a new pose only once the last result has gone to its output
//   register. a reached result skips the cosine pass and the mix and drive
//   steps, a zero position error skips rotate, vector and distance. goal
//   writes are taken while the back part is idle.
// Reset
//   synchronous, active high: goal zero, not tracking, registers at defaults,
//   queue empty, no result pending.
// Stall
//   a held result keeps its register; the back part waits, while the front
//   register and the QUEUE_DEPTH entry queue keep taking input beats until full.
module polar_pose_tracking_controller import ppt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     operation,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [HEAD_W-1:0] heading,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OUT_W-1:0]       speed,
  output logic signed [OUT_W-1:0]       turn_rate,
  output logic                          reached,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  cfg_t     cfg;
  reg_idx_t widx;
  logic     wr_en;

  // front to queue
  logic   q_push;
  entry_t q_push_entry;
  logic   q_full;

  // queue to back
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_gain     <= SPEED_GAIN_RST;
      cfg.alpha_gain     <= ALPHA_GAIN_RST;
      cfg.beta_gain      <= BETA_GAIN_RST;
      cfg.speed_limit    <= SPEED_LIMIT_RST;
      cfg.turn_limit     <= TURN_LIMIT_RST;
      cfg.reach_distance <= REACH_DIST_RST;
      cfg.reach_angle    <= REACH_ANGLE_RST;
    end else if (wr_en) begin
      unique case (widx)
        REG_SPEED_GAIN:  cfg.speed_gain     <= pwdata[GAIN_W-1:0];
        REG_ALPHA_GAIN:  cfg.alpha_gain     <= pwdata[GAIN_W-1:0];
        REG_BETA_GAIN:   cfg.beta_gain      <= pwdata[GAIN_W-1:0];
        REG_SPEED_LIMIT: cfg.speed_limit    <= pwdata[LIM_W-1:0];
        REG_TURN_LIMIT:  cfg.turn_limit     <= pwdata[LIM_W-1:0];
        REG_REACH_DIST:  cfg.reach_distance <= pwdata[RDIST_W-1:0];
        REG_REACH_ANGLE: cfg.reach_angle    <= pwdata[RANG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back of the raw register bits
  always_comb begin
    unique case (widx)
      REG_SPEED_GAIN:  prdata = PDATA_W'(cfg.speed_gain);
      REG_ALPHA_GAIN:  prdata = PDATA_W'(cfg.alpha_gain);
      REG_BETA_GAIN:   prdata = PDATA_W'(cfg.beta_gain);
      REG_SPEED_LIMIT: prdata = PDATA_W'(cfg.speed_limit);
      REG_TURN_LIMIT:  prdata = PDATA_W'(cfg.turn_limit);
      REG_REACH_DIST:  prdata = PDATA_W'(cfg.reach_distance);
      REG_REACH_ANGLE: prdata = PDATA_W'(cfg.reach_angle);
      default:         prdata = '0;
    endcase
  end

  ppt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading    (heading),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full)
  );

  ppt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  ppt_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .speed     (speed),
    .turn_rate (turn_rate),
    .reached   (reached)
  );

  // a reached beat carries zero drive
  a_reached_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reached |-> speed == '0 && turn_rate == '0)
    else $error("reached beat with nonzero drive");

  // the back part only pops a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // turn rate stays inside the configured limit
  a_turn_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turn_rate <= $signed({1'b0, cfg.turn_limit})
               && turn_rate >= -$signed({1'b0, cfg.turn_limit}))
    else $error("turn rate beyond limit");

  // nothing is shown straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: bench/polar_pose_tracking_controller_tb.sv
// polar_pose_tracking_controller_tb: self-checking bench for the polar pose tracking controller
// drives target and pose beats, writes registers over apb, predicts every result in fixed point
// depends on ppt_pkg and the rtl under rtl/core
`timescale 1ns / 100ps

module polar_pose_tracking_controller_tb;
  import ppt_pkg::*;

  // fixed-point constants, q30 (KK20 in q20)
  localparam longint PI30     = 64'sd3373259426;
  localparam longint TWOPI30  = 64'sd6746518852;
  localparam longint HALFPI30 = 64'sd1686629713;
  localparam longint ONE30    = 64'sd1073741824;
  localparam longint GAINK30  = 64'sd652032874;
  localparam longint KK20     = 64'sd386669;
  localparam int     STEPS    = CORDIC_STEPS_DEF;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_POSE;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [HEAD_W-1:0] heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] speed;
  logic signed [OUT_W-1:0] turn_rate;
  logic reached;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  polar_pose_tracking_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .speed(speed), .turn_rate(turn_rate), .reached(reached),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic signed [OUT_W-1:0] speed;
    logic signed [OUT_W-1:0] turn_rate;
    logic                    reached;
  } drive_cmd_t;

  // predictor copy of the registers and goal
  cfg_t   cfg_m;
  longint goal_x_m, goal_y_m, goal_h_m;
  bit     tracking_m;

  drive_cmd_t expected_cmds[$];
  int  n_errors = 0;
  longint cycle_count = 0;
  bit  in_noidle = 1'b0;
  bit  out_noidle = 1'b0;
  int  hold_off = 0;         // receiver hold-off request, in cycles

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // floor division by 2^n
  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  // wrap a q30 angle to (-pi, pi]
  function automatic longint wrap_angle(longint a);
    longint r;
    r = a % TWOPI30;
    if (r < 0) r += TWOPI30;
    if (r > PI30) r -= TWOPI30;
    return r;
  endfunction

  function automatic longint q16_round(longint a);
    return shr_floor(a + 8192, 14);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24];
    t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
          64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
          64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
          64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // rotate (x, y) counterclockwise by z, gain kept
  task automatic rotate_vec(inout longint x, inout longint y, input longint z);
    longint a, b, na, nb;
    a = x;
    b = y;
    if (z > HALFPI30) begin
      z -= PI30; a = -a; b = -b;
    end else if (z < -HALFPI30) begin
      z += PI30; a = -a; b = -b;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        na = a - shr_floor(b, i); nb = b + shr_floor(a, i); z -= atan_step(i);
      end else begin
        na = a + shr_floor(b, i); nb = b - shr_floor(a, i); z += atan_step(i);
      end
      a = na;
      b = nb;
    end
    x = a;
    y = b;
  endtask

  // angle of (x, y); x returns the gained length
  task automatic vector_angle(inout longint x, input longint y, output longint ang);
    longint a, b, z, na, nb;
    a = x;
    b = y;
    z = 0;
    if (a < 0) begin
      z = (b >= 0) ? PI30 : -PI30;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (b < 0) begin
        na = a - shr_floor(b, i); nb = b + shr_floor(a, i); z -= atan_step(i);
      end else begin
        na = a + shr_floor(b, i); nb = b - shr_floor(a, i); z += atan_step(i);
      end
      a = na;
      b = nb;
    end
    x = a;
    ang = z;
  endtask

  // works out the drive command a beat causes, if any
  task automatic predict_drive(input logic op, input longint px, input longint py,
                               input longint ph);
    longint th, dth, ex, ey, goal_dist, alpha, mag, beta, dth16, a16, b16, abs_dth;
    longint v, cx, cy, spd, trn;
    drive_cmd_t cmd;
    if (op == OP_TARGET) begin
      goal_x_m = px;
      goal_y_m = py;
      goal_h_m = ph;
      tracking_m = 1'b1;
      return;
    end
    if (!tracking_m) return;
    th = wrap_angle(ph * 16384);
    dth = wrap_angle((goal_h_m - ph) * 16384);
    ex = (goal_x_m - px) * 256;
    ey = (goal_y_m - py) * 256;
    goal_dist = 0;
    alpha = 0;
    if (ex != 0 || ey != 0) begin
      rotate_vec(ex, ey, wrap_angle(-th));
      mag = ex;
      vector_angle(mag, ey, alpha);
      alpha = wrap_angle(alpha);
      goal_dist = shr_floor(mag * KK20 + (64'sd1 <<< 27), 28);
    end
    beta = wrap_angle(dth - alpha);
    dth16 = q16_round(dth);
    a16 = q16_round(alpha);
    b16 = q16_round(beta);
    abs_dth = dth16 < 0 ? -dth16 : dth16;
    spd = 0;
    trn = 0;
    cmd.reached = 1'b0;
    if (goal_dist < longint'(cfg_m.reach_distance)
        && abs_dth < longint'(cfg_m.reach_angle)) begin
      cmd.reached = 1'b1;
      tracking_m = 1'b0;
    end else begin
      cx = GAINK30;
      cy = 0;
      v = clamp_sym(shr_floor(longint'(cfg_m.speed_gain) * goal_dist, 16),
                    longint'(cfg_m.speed_limit));
      rotate_vec(cx, cy, alpha);
      if (cx < 0) cx = 0;
      if (cx > ONE30) cx = ONE30;
      spd = shr_floor(v * cx, 30);
      trn = clamp_sym(shr_floor(longint'(cfg_m.alpha_gain) * a16
                                + longint'(cfg_m.beta_gain) * b16, 16),
                      longint'(cfg_m.turn_limit));
    end
    cmd.speed = spd[OUT_W-1:0];
    cmd.turn_rate = trn[OUT_W-1:0];
    expected_cmds.push_back(cmd);
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polar_pose_tracking_controller test failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= out_noidle || ($urandom_range(0, 99) >= 30);
    end
  end

  // result checker, one beat at a time
  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (speed !== exp_cmd.speed) begin
          $error("speed expected %0d actual %0d", exp_cmd.speed, speed);
          n_errors++;
        end
        if (turn_rate !== exp_cmd.turn_rate) begin
          $error("turn_rate expected %0d actual %0d", exp_cmd.turn_rate, turn_rate);
          n_errors++;
        end
        if (reached !== exp_cmd.reached) begin
          $error("reached expected %0d actual %0d", exp_cmd.reached, reached);
          n_errors++;
        end
      end
    end
  end

  // one input beat, with a random gap before it; valid drops only in a gap
  task automatic send_beat(input logic op, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y,
                           input logic signed [HEAD_W-1:0] h);
    while (!in_noidle && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pos_x <= x;
    pos_y <= y;
    heading <= h;
    do @(posedge clk); while (!in_ready);
    predict_drive(op, longint'(x), longint'(y), longint'(h));
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (3 * STEPS + 40) @(posedge clk);
  endtask

  // apb write, setup then access; only while idle
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPEED_GAIN:  cfg_m.speed_gain = val[GAIN_W-1:0];
      REG_ALPHA_GAIN:  cfg_m.alpha_gain = val[GAIN_W-1:0];
      REG_BETA_GAIN:   cfg_m.beta_gain = val[GAIN_W-1:0];
      REG_SPEED_LIMIT: cfg_m.speed_limit = val[LIM_W-1:0];
      REG_TURN_LIMIT:  cfg_m.turn_limit = val[LIM_W-1:0];
      REG_REACH_DIST:  cfg_m.reach_distance = val[RDIST_W-1:0];
      REG_REACH_ANGLE: cfg_m.reach_angle = val[RANG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] ag,
                           input logic [GAIN_W-1:0] bg, input logic [LIM_W-1:0] sl,
                           input logic [LIM_W-1:0] tl, input logic [RDIST_W-1:0] rd,
                           input logic [RANG_W-1:0] ra);
    write_reg(REG_SPEED_GAIN, PDATA_W'(sg));
    write_reg(REG_ALPHA_GAIN, PDATA_W'(ag));
    write_reg(REG_BETA_GAIN, PDATA_W'(bg));
    write_reg(REG_SPEED_LIMIT, PDATA_W'(sl));
    write_reg(REG_TURN_LIMIT, PDATA_W'(tl));
    write_reg(REG_REACH_DIST, PDATA_W'(rd));
    write_reg(REG_REACH_ANGLE, PDATA_W'(ra));
  endtask

  // random offset: mostly near the goal, sometimes anywhere
  function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] c);
    case ($urandom_range(0, 3))
      0: return c + $signed($urandom_range(0, 8191)) - 4096;
      1: return c + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return c + $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  // extremes of fields, both operations, idle poses, zero error, wrapping
  task automatic test_directed();
    send_beat(OP_POSE, 32'sd1000, -32'sd1000, 24'sd0);         // idle pose
    send_beat(OP_TARGET, 32'sd0, 32'sd0, 24'sd0);
    send_beat(OP_POSE, 32'sd0, 32'sd0, 24'sd0);                // zero error, reached
    send_beat(OP_POSE, 32'sd0, 32'sd0, 24'sd0);                // idle again
    send_beat(OP_TARGET, 32'sd131072, 32'sd65536, 24'sd102944);
    send_beat(OP_POSE, 32'sd131072, 32'sd65536, 24'sd0);       // zero distance, heading off
    send_beat(OP_POSE, 32'sh7FFFFFFF, 32'sh80000000, 24'sh7FFFFF);
    send_beat(OP_POSE, 32'sh80000000, 32'sh7FFFFFFF, 24'sh800000);
    send_beat(OP_TARGET, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'sh7FFFFF);  // target while tracking
    send_beat(OP_POSE, 32'sh80000000, 32'sh80000000, 24'sh800000);
    send_beat(OP_POSE, 32'sd0, 32'sd0, -24'sd205887);
    send_beat(OP_POSE, -32'sd65536, 32'sd0, 24'sd205887);      // goal behind
    send_beat(OP_TARGET, -32'sd65536, 32'sd0, 24'sd411775);    // heading past 2 pi
    send_beat(OP_POSE, 32'sd0, 32'sd0, -24'sd411775);
    send_beat(OP_POSE, -32'sd65536, 32'sd100, 24'sd411775);    // reached after wrap
    drain();
  endtask

  // random tracking runs: a target then random poses around it
  task automatic test_random_tracking(input int n_items);
    logic signed [POS_W-1:0] gx, gy;
    logic signed [HEAD_W-1:0] gh;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      gx = ($urandom_range(0, 9) == 0) ? $urandom : near(32'sd0);
      gy = ($urandom_range(0, 9) == 0) ? $urandom : near(32'sd0);
      gh = HEAD_W'($urandom);
      send_beat(OP_TARGET, gx, gy, gh);
      sent++;
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 5) == 0)
          send_beat(OP_POSE, gx + $signed($urandom_range(0, 4000)) - 2000,
                    gy + $signed($urandom_range(0, 4000)) - 2000,
                    HEAD_W'(gh + $signed($urandom_range(0, 20000)) - 10000));
        else
          send_beat($urandom_range(0, 19) == 0 ? OP_TARGET : OP_POSE,
                    near(gx), near(gy), HEAD_W'($urandom));
        sent++;
      end
    end
  endtask

  // receiver held off while the sender keeps offering poses
  task automatic test_backpressure();
    send_beat(OP_TARGET, 32'sh00100000, -32'sh00200000, 24'sd50000);
    hold_off <= 2000;
    in_noidle = 1'b1;
    repeat (20) send_beat(OP_POSE, near(32'sd0), near(32'sd0), HEAD_W'($urandom));
    in_noidle = 1'b0;
    drain();
  endtask

  initial begin
    cfg_m.speed_gain = SPEED_GAIN_RST;
    cfg_m.alpha_gain = ALPHA_GAIN_RST;
    cfg_m.beta_gain = BETA_GAIN_RST;
    cfg_m.speed_limit = SPEED_LIMIT_RST;
    cfg_m.turn_limit = TURN_LIMIT_RST;
    cfg_m.reach_distance = REACH_DIST_RST;
    cfg_m.reach_angle = REACH_ANGLE_RST;
    goal_x_m = 0;
    goal_y_m = 0;
    goal_h_m = 0;
    tracking_m = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_tracking(150);
    drain();

    // extreme settings: largest gains and limits
    write_all(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 18'h3FFFF, 18'h3FFFF, 24'hFFFFFF, 18'd205887);
    test_random_tracking(60);
    drain();
    // zero limits and thresholds
    write_all(24'h800000, 24'h800000, 24'h7FFFFF, 18'd0, 18'd0, 24'd0, 18'd0);
    test_random_tracking(60);
    drain();

    // no idling on either side for a stretch
    in_noidle = 1'b1;
    out_noidle = 1'b1;
    write_all(24'd65536, 24'd200000, -24'd100000, 18'd131072, 18'd98304, 24'd65536, 18'd20000);
    test_random_tracking(80);
    drain();
    in_noidle = 1'b0;
    out_noidle = 1'b0;

    write_all(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), LIM_W'($urandom),
              LIM_W'($urandom), RDIST_W'($urandom_range(0, 400000)),
              RANG_W'($urandom_range(0, 205887)));
    test_random_tracking(80);
    drain();
    write_all(24'd328, 24'd360448, -24'd249037, 18'd65536, 18'd65536, 24'd2621, 18'd11438);
    test_random_tracking(100);
    drain();

    if (n_errors == 0) begin
      $display("polar_pose_tracking_controller test passed");
    end else begin
      $display("polar_pose_tracking_controller test failed");
    end
    $finish;
  end

endmodule

FILE: polar_pose_tracking_controller.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_front.sv
rtl/core/ppt_queue.sv
rtl/core/ppt_back.sv
rtl/core/polar_pose_tracking_controller.sv
bench/polar_pose_tracking_controller_tb.sv
